// File: src/cnlc_pkg.sv
package cnlc_pkg;

  localparam int CardW = 63;
  localparam int DigN  = 19;
  localparam int BcdW  = 4 * DigN;
  localparam int IdxW  = 5;
  localparam int ItW   = 6;
  localparam int CntW  = 5;

  localparam logic [ItW-1:0]  LastBit   = ItW'(CardW - 1);
  localparam logic [IdxW-1:0] LastDigit = IdxW'(DigN - 1);

  typedef logic [1:0] issuer_t;
  localparam issuer_t CLS_INVALID = 2'd0;
  localparam issuer_t CLS_FIFTEEN = 2'd1;
  localparam issuer_t CLS_SIXTEEN = 2'd2;
  localparam issuer_t CLS_FOUR    = 2'd3;

  typedef struct packed {
    logic              luhn_ok;
    logic [CntW-1:0]   digit_count;
    issuer_t           issuer_class;
  } cnlc_result_t;

  typedef struct packed {
    logic start;
    logic done;
  } cnlc_hs_t;

endpackage

// File: src/cnlc_b2d.sv
module cnlc_b2d (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cnlc_pkg::CardW-1:0]  value,
  output logic                        done,
  output logic [cnlc_pkg::BcdW-1:0]   bcd
);
  import cnlc_pkg::*;

  logic             busy;
  logic [ItW-1:0]   cnt;
  logic [CardW-1:0] bin;
  logic [BcdW-1:0]  adj;

  // add-3 on each digit of five or more, then shift one binary bit in
  always_comb begin
    for (int i = 0; i < DigN; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + ItW'(1);
        if (cnt == LastBit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[CardW-2:0], 1'b0};
      bcd <= {adj[BcdW-2:0], bin[CardW-1]};
    end
  end

endmodule

// File: src/cnlc_luhn.sv
module cnlc_luhn (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cnlc_pkg::BcdW-1:0]   bcd,
  output logic                        done,
  output cnlc_pkg::cnlc_result_t      result
);
  import cnlc_pkg::*;

  logic            busy;
  logic            fin;
  logic [IdxW-1:0] idx;
  logic [3:0]      sum;
  logic [CntW-1:0] count;
  logic [3:0]      dig;
  logic [3:0]      term;
  logic [4:0]      acc;
  logic [3:0]      sum_next;
  logic            ok;
  issuer_t         cls;

  assign dig = bcd[idx*4 +: 4];

  // even positions from the right are doubled, digit sum of the product
  always_comb begin
    if (idx[0]) begin
      if (dig >= 4'd5) begin
        term = 4'((5'(dig) << 1) - 5'd9);
      end else begin
        term = dig << 1;
      end
    end else begin
      term = dig;
    end
    acc = 5'(sum) + 5'(term);
    if (acc >= 5'd10) begin
      sum_next = 4'(acc - 5'd10);
    end else begin
      sum_next = acc[3:0];
    end
  end

  always_comb begin
    ok  = (sum == 4'd0);
    cls = CLS_INVALID;
    if (ok) begin
      unique if (count == CntW'(16)) begin
        if (bcd[60 +: 4] == 4'd5 && bcd[56 +: 4] >= 4'd1 && bcd[56 +: 4] <= 4'd5) begin
          cls = CLS_SIXTEEN;
        end else if (bcd[60 +: 4] == 4'd4) begin
          cls = CLS_FOUR;
        end
      end else if (count == CntW'(15)) begin
        if (bcd[56 +: 4] == 4'd3 && (bcd[52 +: 4] == 4'd4 || bcd[52 +: 4] == 4'd7)) begin
          cls = CLS_FIFTEEN;
        end
      end else if (count == CntW'(13)) begin
        if (bcd[48 +: 4] == 4'd4) begin
          cls = CLS_FOUR;
        end
      end else begin
        cls = CLS_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + IdxW'(1);
        if (idx == LastDigit) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum   <= '0;
      count <= '0;
    end else if (busy) begin
      sum <= sum_next;
      if (dig != 4'd0) begin
        count <= CntW'(idx) + CntW'(1);
      end
    end
    if (fin) begin
      result.issuer_class <= cls;
      result.digit_count  <= count;
      result.luhn_ok      <= ok;
    end
  end

endmodule

// File: src/card_number_luhn_classifier_top.sv
// Luhn mod-10 check and issuer class of one binary card number per request.
// An accepted number goes through a shift-and-add-3 binary to decimal
// converter, one bit a cycle, then one decimal digit a cycle is read from
// the least significant end to form the digit count and the Luhn sum, then
// the class is formed and registered. The result is loaded into the output
// register once that is free, and only then can the next request be taken.
// s_tready is low while a number is in work; a finished result waits in the
// output register and the next number may be taken meanwhile.
// Result codes: 0 invalid, 1 fifteen digits led by 34 or 37, 2 sixteen
// digits led by 51 to 55, 3 leading 4 with 13 or 16 digits.
module card_number_luhn_classifier_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [62:0] card_number, [63] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [1:0] issuer_class, [6:2] digit_count, [7] luhn_ok
);
  import cnlc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t          state;
  state_t          state_next;
  cnlc_hs_t        conv_hs;
  cnlc_hs_t        scan_hs;
  logic [BcdW-1:0] bcd;
  cnlc_result_t    result;
  logic            load;

  assign s_tready      = (state == ST_IDLE);
  assign conv_hs.start = s_tvalid && s_tready;
  assign scan_hs.start = conv_hs.done;
  assign load          = (state == ST_OUT) && (!m_tvalid || m_tready);

  cnlc_b2d u_b2d (
    .clk   (clk),
    .rst   (rst),
    .start (conv_hs.start),
    .value (s_tdata[CardW-1:0]),
    .done  (conv_hs.done),
    .bcd   (bcd)
  );

  cnlc_luhn u_luhn (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_hs.start),
    .bcd    (bcd),
    .done   (scan_hs.done),
    .result (result)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (conv_hs.start) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (conv_hs.done) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hs.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= result;
    end
  end

endmodule
